// ===== rtl/hpsk_pkg.sv =====
// Package for the heater controller: command codes, register indexes,
// setpoint limits and the shared types. No dependencies.
package hpsk_pkg;

	localparam int TEMP_W  = 12;
	localparam int SP_W    = 6;
	localparam int ERR_W   = 8;
	localparam int DRIVE_W = 16;
	localparam int INTEG_W = 17;
	localparam int GAIN_W  = 8;
	localparam int TICK_W  = 8;
	localparam int SUM_W   = 21;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	localparam logic [2:0] OP_SAMPLE  = 3'd0;
	localparam logic [2:0] OP_KEY_UP  = 3'd1;
	localparam logic [2:0] OP_KEY_DN  = 3'd2;
	localparam logic [2:0] OP_TICK    = 3'd3;
	localparam logic [2:0] OP_LOAD_SP = 3'd4;

	localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
	localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
	localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
	localparam logic [2:0] REG_INTEG_UPPER = 3'd3;
	localparam logic [2:0] REG_INTEG_LOWER = 3'd4;
	localparam logic [2:0] REG_DRIVE_UPPER = 3'd5;
	localparam logic [2:0] REG_DRIVE_LOWER = 3'd6;
	localparam logic [2:0] REG_MODE_TMO    = 3'd7;

	localparam logic [SP_W-1:0]   SP_MAX    = 6'd55;
	localparam logic [SP_W-1:0]   SP_MIN    = 6'd10;
	localparam logic [TICK_W-1:0] TICKS_SAT = 8'd255;

	typedef struct packed {
		logic [GAIN_W-1:0]         gain_prop;
		logic [GAIN_W-1:0]         gain_integ;
		logic [GAIN_W-1:0]         gain_deriv;
		logic signed [INTEG_W-1:0] integ_upper;
		logic signed [INTEG_W-1:0] integ_lower;
		logic [DRIVE_W-1:0]        drive_upper;
		logic [DRIVE_W-1:0]        drive_lower;
		logic [TICK_W-1:0]         mode_timeout;
	} hpsk_cfg_t;

	typedef struct packed {
		logic               heater_on;
		logic [DRIVE_W-1:0] drive_level;
	} hpsk_law_t;

endpackage

// ===== rtl/hpsk_law.sv =====
// PID control law for the heater controller: proportional, clamped integral
// and derivative terms, then the drive clamp. Depends on hpsk_pkg.
module hpsk_law
	import hpsk_pkg::*;
(
	input  hpsk_cfg_t               cfg,
	input  logic signed [ERR_W-1:0] err,
	input  logic signed [ERR_W-1:0] err1,
	input  logic signed [ERR_W-1:0] err2,
	output hpsk_law_t               law
);

	logic signed [ERR_W:0]     de1;
	logic signed [ERR_W+1:0]   de2;
	logic signed [17:0]        p_term;
	logic signed [INTEG_W-1:0] i_raw;
	logic signed [INTEG_W-1:0] i_hi;
	logic signed [INTEG_W-1:0] i_term;
	logic signed [18:0]        d_term;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   lim_hi;
	logic signed [SUM_W-1:0]   lim_lo;
	logic signed [SUM_W-1:0]   lvl_hi;
	logic signed [SUM_W-1:0]   lvl;

	always_comb begin
		de1    = (ERR_W+1)'(err) - (ERR_W+1)'(err1);
		de2    = (ERR_W+2)'(err) - ((ERR_W+2)'(err1) <<< 1) + (ERR_W+2)'(err2);
		p_term = $signed({1'b0, cfg.gain_prop}) * de1;
		i_raw  = $signed({1'b0, cfg.gain_integ}) * err;
		d_term = $signed({1'b0, cfg.gain_deriv}) * de2;
		i_hi   = (i_raw > cfg.integ_upper) ? cfg.integ_upper : i_raw;
		i_term = (i_hi < cfg.integ_lower) ? cfg.integ_lower : i_hi;
		sum    = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
		lim_hi = $signed({{(SUM_W-DRIVE_W){1'b0}}, cfg.drive_upper});
		lim_lo = $signed({{(SUM_W-DRIVE_W){1'b0}}, cfg.drive_lower});
		lvl_hi = (sum > lim_hi) ? lim_hi : sum;
		lvl    = (lvl_hi < lim_lo) ? lim_lo : lvl_hi;
		law.heater_on   = !sum[SUM_W-1] && !err[ERR_W-1];
		law.drive_level = law.heater_on ? lvl[DRIVE_W-1:0] : '0;
	end

endmodule

// ===== rtl/heater_pid_with_setpoint_keys.sv =====
// Top level of the heater controller: input stage, command decode, state,
// configuration registers and result register. Depends on hpsk_pkg, hpsk_law.
//
// One command per transaction: sample, up key, down key, tick or setpoint load.
// Every command yields exactly one result. A command is held in the input
// stage, where the error, the PID law and the key and timeout logic run
// in a single pass, and its result is written to the output register in the
// same cycle as the state update. A command goes through the input stage
// register and then the output register; a new command is accepted every
// cycle while the output side keeps taking results. Configuration writes
// take effect on the next cycle and are meant for idle periods only.
module heater_pid_with_setpoint_keys
	import hpsk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [2:0] opcode, [14:3] temperature, [20:15] load_value, [23:21] zero
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] control_ran, [1] heater_on, [17:2] drive_level, [23:18] setpoint_now,
	// [24] in_set_mode, [31:25] zero
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [INTEG_W-1:0]  cfg_data
);

	hpsk_cfg_t cfg_q;

	logic                       valid_s1;
	logic [2:0]                 op_s1;
	logic signed [TEMP_W-1:0]   temp_s1;
	logic [SP_W-1:0]            load_s1;

	logic [SP_W-1:0]            setpoint_q;
	logic                       set_mode_q;
	logic [TICK_W-1:0]          ticks_q;
	logic signed [ERR_W-1:0]    err_latest_q;
	logic signed [ERR_W-1:0]    err_before_q;

	logic                       out_valid_q;
	logic [M_DATA_W-1:0]        out_data_q;

	logic                       advance;
	logic signed [TEMP_W:0]     mag;
	logic signed [TEMP_W:0]     diff;
	logic signed [TEMP_W:0]     diff_adj;
	logic signed [ERR_W-1:0]    err;
	hpsk_law_t                  law;

	logic [SP_W-1:0]            setpoint_d;
	logic                       set_mode_d;
	logic [TICK_W-1:0]          ticks_d;
	logic [TICK_W-1:0]          ticks_inc;
	logic                       ran_d;
	logic                       shift_err;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		mag      = temp_s1[TEMP_W-1] ? -(TEMP_W+1)'(temp_s1) : (TEMP_W+1)'(temp_s1);
		diff     = $signed({{(TEMP_W+1-SP_W-4){1'b0}}, setpoint_q, 4'b0000}) - mag;
		diff_adj = diff[TEMP_W] ? diff + (TEMP_W+1)'(15) : diff;
		err      = diff_adj[ERR_W+3:4];
	end

	hpsk_law u_law (
		.cfg  (cfg_q),
		.err  (err),
		.err1 (err_latest_q),
		.err2 (err_before_q),
		.law  (law)
	);

	always_comb begin
		setpoint_d = setpoint_q;
		set_mode_d = set_mode_q;
		ticks_d    = ticks_q;
		ran_d      = 1'b0;
		shift_err  = 1'b0;
		ticks_inc  = (ticks_q < TICKS_SAT) ? ticks_q + TICK_W'(1) : ticks_q;
		unique case (op_s1)
			OP_SAMPLE: begin
				ran_d     = !set_mode_q;
				shift_err = !set_mode_q;
			end
			OP_KEY_UP: begin
				set_mode_d = 1'b1;
				ticks_d    = '0;
				if (setpoint_q < SP_MAX) begin
					setpoint_d = setpoint_q + SP_W'(1);
				end
			end
			OP_KEY_DN: begin
				set_mode_d = 1'b1;
				ticks_d    = '0;
				if (setpoint_q > SP_MIN) begin
					setpoint_d = setpoint_q - SP_W'(1);
				end
			end
			OP_TICK: begin
				if (set_mode_q) begin
					if (ticks_inc > cfg_q.mode_timeout) begin
						ticks_d    = '0;
						set_mode_d = 1'b0;
					end else begin
						ticks_d = ticks_inc;
					end
				end
			end
			OP_LOAD_SP: begin
				setpoint_d = load_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop    <= 8'd40;
			cfg_q.gain_integ   <= 8'd80;
			cfg_q.gain_deriv   <= 8'd50;
			cfg_q.integ_upper  <= 17'sd1000;
			cfg_q.integ_lower  <= -17'sd1000;
			cfg_q.drive_upper  <= 16'd1000;
			cfg_q.drive_lower  <= 16'd0;
			cfg_q.mode_timeout <= 8'd150;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_PROP:   cfg_q.gain_prop    <= cfg_data[GAIN_W-1:0];
				REG_GAIN_INTEG:  cfg_q.gain_integ   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_DERIV:  cfg_q.gain_deriv   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_UPPER: cfg_q.integ_upper  <= $signed(cfg_data);
				REG_INTEG_LOWER: cfg_q.integ_lower  <= $signed(cfg_data);
				REG_DRIVE_UPPER: cfg_q.drive_upper  <= cfg_data[DRIVE_W-1:0];
				REG_DRIVE_LOWER: cfg_q.drive_lower  <= cfg_data[DRIVE_W-1:0];
				REG_MODE_TMO:    cfg_q.mode_timeout <= cfg_data[TICK_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tdata[2:0];
			temp_s1 <= $signed(s_tdata[14:3]);
			load_s1 <= s_tdata[20:15];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= '0;
			set_mode_q   <= 1'b0;
			ticks_q      <= '0;
			err_latest_q <= '0;
			err_before_q <= '0;
		end else if (advance) begin
			setpoint_q <= setpoint_d;
			set_mode_q <= set_mode_d;
			ticks_q    <= ticks_d;
			if (shift_err) begin
				err_before_q <= err_latest_q;
				err_latest_q <= err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {7'b0, set_mode_d, setpoint_d,
				ran_d ? law.drive_level : {DRIVE_W{1'b0}},
				ran_d && law.heater_on, ran_d};
		end
	end

endmodule

// ===== rtl/hpsk_checker.sv =====
// Port checker for the heater controller, bound to the top level.
// Depends on hpsk_pkg.
module hpsk_checker
	import hpsk_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ran_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[24])
		else $error("control ran in set mode");

	a_on_ran: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("heater on without control");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[17:2] == '0)
		else $error("drive level set with heater off");

endmodule

bind heater_pid_with_setpoint_keys hpsk_checker u_hpsk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for heater_pid_with_setpoint_keys: directed and random command streams,
// each result checked against the controller predictor held in a scoreboard class.
// Depends on hpsk_pkg and the heater_pid_with_setpoint_keys RTL.
module testbench;
	import hpsk_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;

	// [2:0] opcode, [14:3] temperature, [20:15] load_value, [23:21] zero
	typedef struct packed {
		logic [2:0]               pad;
		logic [SP_W-1:0]          load_value;
		logic signed [TEMP_W-1:0] temperature;
		logic [2:0]               opcode;
	} heater_cmd_t;

	// [0] control_ran, [1] heater_on, [17:2] drive_level, [23:18] setpoint_now,
	// [24] in_set_mode, [31:25] zero
	typedef struct packed {
		logic [6:0]         pad;
		logic               in_set_mode;
		logic [SP_W-1:0]    setpoint_now;
		logic [DRIVE_W-1:0] drive_level;
		logic               heater_on;
		logic               control_ran;
	} heater_result_t;

	localparam hpsk_cfg_t RESET_SETTINGS = '{
		gain_prop: 8'd40, gain_integ: 8'd80, gain_deriv: 8'd50,
		integ_upper: 17'sd1000, integ_lower: -17'sd1000,
		drive_upper: 16'd1000, drive_lower: 16'd0, mode_timeout: 8'd150
	};

	class heater_scoreboard;
		hpsk_cfg_t               cfg;
		logic [SP_W-1:0]         setpoint;
		logic                    set_mode;
		logic [TICK_W-1:0]       mode_ticks;
		logic signed [ERR_W-1:0] err_latest;
		logic signed [ERR_W-1:0] err_before;
		heater_result_t          pending_results[$];
		int                      mismatches;
		int                      commands_seen;
		int                      results_seen;
		int                      laws_run;

		function new();
			cfg = RESET_SETTINGS;
			setpoint = '0;
			set_mode = 1'b0;
			mode_ticks = '0;
			err_latest = '0;
			err_before = '0;
			mismatches = 0;
			commands_seen = 0;
			results_seen = 0;
			laws_run = 0;
		endfunction

		function void set_register(logic [2:0] reg_index, logic [INTEG_W-1:0] value);
			unique case (reg_index)
				REG_GAIN_PROP:   cfg.gain_prop    = value[GAIN_W-1:0];
				REG_GAIN_INTEG:  cfg.gain_integ   = value[GAIN_W-1:0];
				REG_GAIN_DERIV:  cfg.gain_deriv   = value[GAIN_W-1:0];
				REG_INTEG_UPPER: cfg.integ_upper  = value;
				REG_INTEG_LOWER: cfg.integ_lower  = value;
				REG_DRIVE_UPPER: cfg.drive_upper  = value[DRIVE_W-1:0];
				REG_DRIVE_LOWER: cfg.drive_lower  = value[DRIVE_W-1:0];
				REG_MODE_TMO:    cfg.mode_timeout = value[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_command(heater_cmd_t cmd);
			heater_result_t res;
			int magnitude;
			int err;
			int prev;
			int older;
			int integ;
			int total;
			res = '0;
			commands_seen++;
			unique case (cmd.opcode)
				OP_SAMPLE: begin
					if (!set_mode) begin
						magnitude = $signed(cmd.temperature);
						if (magnitude < 0)
							magnitude = -magnitude;
						// whole degrees, truncated toward zero
						err = (int'(setpoint) * 16 - magnitude) / 16;
						prev = err_latest;
						older = err_before;
						err_before = err_latest;
						err_latest = err[ERR_W-1:0];
						integ = int'(cfg.gain_integ) * err;
						if (integ > $signed(cfg.integ_upper))
							integ = $signed(cfg.integ_upper);
						if (integ < $signed(cfg.integ_lower))
							integ = $signed(cfg.integ_lower);
						total = int'(cfg.gain_prop) * (err - prev) + integ
							+ int'(cfg.gain_deriv) * (err - 2 * prev + older);
						res.control_ran = 1'b1;
						laws_run++;
						if (total >= 0 && err >= 0) begin
							if (total > int'(cfg.drive_upper))
								total = int'(cfg.drive_upper);
							if (total < int'(cfg.drive_lower))
								total = int'(cfg.drive_lower);
							res.heater_on = 1'b1;
							res.drive_level = total[DRIVE_W-1:0];
						end
					end
				end
				OP_KEY_UP, OP_KEY_DN: begin
					set_mode = 1'b1;
					mode_ticks = '0;
					if (cmd.opcode == OP_KEY_UP && setpoint < SP_MAX)
						setpoint++;
					if (cmd.opcode == OP_KEY_DN && setpoint > SP_MIN)
						setpoint--;
				end
				OP_TICK: begin
					if (set_mode) begin
						if (mode_ticks < TICKS_SAT)
							mode_ticks++;
						if (mode_ticks > cfg.mode_timeout) begin
							mode_ticks = '0;
							set_mode = 1'b0;
						end
					end
				end
				OP_LOAD_SP: setpoint = cmd.load_value;
				default: ;
			endcase
			res.setpoint_now = setpoint;
			res.in_set_mode = set_mode;
			pending_results.push_back(res);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0d, got %0d", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(heater_result_t got);
			heater_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result %h arrived with nothing outstanding", got);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("control_ran", 32'(want.control_ran), 32'(got.control_ran));
				compare_field("heater_on", 32'(want.heater_on), 32'(got.heater_on));
				compare_field("drive_level", 32'(want.drive_level), 32'(got.drive_level));
				compare_field("setpoint_now", 32'(want.setpoint_now),
					32'(got.setpoint_now));
				compare_field("in_set_mode", 32'(want.in_set_mode), 32'(got.in_set_mode));
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [INTEG_W-1:0]  cfg_data;

	heater_scoreboard board;
	bit source_gaps;
	bit sink_stalls;
	int sink_hold_request = 0;
	int settings_used = 1;
	int cycle_count = 0;

	heater_pid_with_setpoint_keys dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("run stalled: limit of %0d cycles reached", CYCLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	function automatic int idle_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int source_gap();
		if (!source_gaps || $urandom_range(0, 99) < 60)
			return 0;
		return idle_length();
	endfunction

	initial begin : sink_driver
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_request > 0) begin
				stall = sink_hold_request;
				sink_hold_request = 0;
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
				m_tready <= 1'b0;
				repeat (idle_length() - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic heater_cmd_t make_cmd(logic [2:0] opcode, logic [TEMP_W-1:0] temperature,
			logic [SP_W-1:0] load_value);
		heater_cmd_t cmd;
		cmd = '0;
		cmd.opcode = opcode;
		cmd.temperature = temperature;
		cmd.load_value = load_value;
		return cmd;
	endfunction

	function automatic heater_cmd_t random_sample();
		int temp;
		if ($urandom_range(0, 3) == 0) begin
			temp = $urandom_range(0, 4095) - 2048;
		end else begin
			temp = int'(board.setpoint) * 16 + int'($urandom_range(0, 320)) - 160;
			if ($urandom_range(0, 3) == 0)
				temp = -temp;
			if (temp > 2047)
				temp = 2047;
			if (temp < -2048)
				temp = -2048;
		end
		return make_cmd(OP_SAMPLE, temp[TEMP_W-1:0], SP_W'($urandom));
	endfunction

	task automatic send_command(input heater_cmd_t cmd);
		int gap;
		gap = source_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= cmd;
		do @(posedge clk); while (!s_tready);
		board.note_command(cmd);
	endtask

	task automatic pause_source();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic await_drain();
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] reg_index, input logic [INTEG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		board.set_register(reg_index, value);
	endtask

	task automatic next_phase(input hpsk_cfg_t s);
		pause_source();
		await_drain();
		repeat (4) @(negedge clk);
		write_register(REG_GAIN_PROP, INTEG_W'(s.gain_prop));
		write_register(REG_GAIN_INTEG, INTEG_W'(s.gain_integ));
		write_register(REG_GAIN_DERIV, INTEG_W'(s.gain_deriv));
		write_register(REG_INTEG_UPPER, s.integ_upper);
		write_register(REG_INTEG_LOWER, s.integ_lower);
		write_register(REG_DRIVE_UPPER, INTEG_W'(s.drive_upper));
		write_register(REG_DRIVE_LOWER, INTEG_W'(s.drive_lower));
		write_register(REG_MODE_TMO, INTEG_W'(s.mode_timeout));
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic hpsk_cfg_t random_settings();
		hpsk_cfg_t s;
		s.gain_prop = GAIN_W'($urandom);
		s.gain_integ = GAIN_W'($urandom);
		s.gain_deriv = GAIN_W'($urandom);
		s.integ_upper = INTEG_W'($urandom_range(0, 30000));
		s.integ_lower = -$signed(INTEG_W'($urandom_range(0, 30000)));
		s.drive_upper = DRIVE_W'($urandom_range(50, 20000));
		s.drive_lower = DRIVE_W'($urandom_range(0, 40));
		s.mode_timeout = TICK_W'($urandom_range(0, 8));
		return s;
	endfunction

	task automatic directed_checks();
		send_command(make_cmd(OP_SAMPLE, 12'd0, 6'd0));
		send_command(make_cmd(OP_SAMPLE, 12'h800, 6'h3f));
		send_command(make_cmd(OP_TICK, 12'hfff, 6'h3f));
		send_command(make_cmd(OP_LOAD_SP, 12'h7ff, 6'd63));
		send_command(make_cmd(OP_SAMPLE, 12'h7ff, 6'd0));
		send_command(make_cmd(OP_SAMPLE, 12'd0, 6'd0));
		send_command(make_cmd(OP_SAMPLE, 12'hfff, 6'd0));
		send_command(make_cmd(OP_SAMPLE, 12'd1008, 6'd0));
		send_command(make_cmd(OP_SAMPLE, 12'd1009, 6'd0));
		send_command(make_cmd(OP_SAMPLE, 12'd1039, 6'd0));
		send_command(make_cmd(OP_SAMPLE, 12'hc00, 6'd0));
		send_command(make_cmd(OP_KEY_UP, 12'h555, 6'h2a));
		send_command(make_cmd(OP_SAMPLE, 12'd16, 6'd0));
		send_command(make_cmd(OP_TICK, 12'd0, 6'd0));
		send_command(make_cmd(OP_LOAD_SP, 12'd0, SP_MAX));
		send_command(make_cmd(OP_KEY_UP, 12'd0, 6'd0));
		send_command(make_cmd(OP_LOAD_SP, 12'd0, SP_MIN));
		send_command(make_cmd(OP_KEY_DN, 12'd0, 6'd0));
		send_command(make_cmd(OP_LOAD_SP, 12'd0, 6'd9));
		send_command(make_cmd(OP_KEY_DN, 12'd0, 6'd0));
		send_command(make_cmd(OP_KEY_UP, 12'd0, 6'd0));
		send_command(make_cmd(3'd5, 12'h7ff, 6'h3f));
		send_command(make_cmd(3'd6, 12'h800, 6'h15));
		send_command(make_cmd(3'd7, 12'hfff, 6'h3f));
	endtask

	task automatic run_traffic(input int budget);
		int sent;
		int roll;
		int count;
		int ticks;
		sent = 0;
		while (sent < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				count = $urandom_range(3, 12);
				repeat (count) send_command(random_sample());
			end else if (roll < 75) begin
				count = $urandom_range(1, 4);
				repeat (count)
					send_command(make_cmd($urandom_range(0, 1) ? OP_KEY_UP : OP_KEY_DN,
						TEMP_W'($urandom), SP_W'($urandom)));
				if ($urandom_range(0, 2) == 0) begin
					send_command(random_sample());
					count++;
				end
				// tick out of set mode, or stop short now and then
				ticks = int'(board.cfg.mode_timeout) + 1 + $urandom_range(0, 2);
				if ($urandom_range(0, 4) == 0)
					ticks = $urandom_range(0, int'(board.cfg.mode_timeout));
				repeat (ticks)
					send_command(make_cmd(OP_TICK, TEMP_W'($urandom), SP_W'($urandom)));
				count += ticks;
			end else if (roll < 87) begin
				count = 1;
				send_command(make_cmd(OP_LOAD_SP, TEMP_W'($urandom),
					SP_W'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(10, 55))));
			end else begin
				count = 1;
				send_command(make_cmd($urandom_range(0, 1) ? OP_TICK : 3'($urandom_range(5, 7)),
					TEMP_W'($urandom), SP_W'($urandom)));
			end
			sent += count;
		end
	endtask

	initial begin : stimulus
		hpsk_cfg_t s;
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		source_gaps = 1'b1;
		sink_stalls = 1'b1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		directed_checks();
		run_traffic(130);

		s = RESET_SETTINGS;
		s.gain_prop = '1;
		s.gain_integ = '1;
		s.gain_deriv = '1;
		s.integ_upper = 17'sd65535;
		s.integ_lower = 17'h10000;
		s.drive_upper = '1;
		s.drive_lower = '0;
		s.mode_timeout = '0;
		next_phase(s);
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		run_traffic(150);

		// crossed limits: lower integral clamp and minimum drive win
		s = random_settings();
		s.integ_upper = -17'sd200;
		s.integ_lower = 17'sd300;
		s.drive_upper = 16'd100;
		s.drive_lower = 16'd700;
		s.mode_timeout = 8'd3;
		next_phase(s);
		sink_stalls = 1'b1;
		run_traffic(60);
		sink_hold_request = HOLD_CYCLES;
		run_traffic(90);

		s = '0;
		s.mode_timeout = 8'd254;
		next_phase(s);
		source_gaps = 1'b1;
		run_traffic(300);

		next_phase(random_settings());
		run_traffic(120);
		next_phase(random_settings());
		sink_stalls = 1'b0;
		run_traffic(120);
		s = random_settings();
		s.drive_upper = '1;
		s.drive_lower = '1;
		next_phase(s);
		sink_stalls = 1'b1;
		run_traffic(120);

		pause_source();
		await_drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d commands over %0d register settings, %0d results,",
			board.commands_seen, settings_used, board.results_seen);
		$display("%0d control-law runs, %0d mismatches", board.laws_run, board.mismatches);
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/hpsk_pkg.sv
rtl/hpsk_law.sv
rtl/heater_pid_with_setpoint_keys.sv
rtl/hpsk_checker.sv
verif/testbench.sv
